// ----- rtl/llh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llh_pkg
// Shared types, codes and constants of the log2 latency histogram engine.
// ----------------------------------------------------------------------------
package llh_pkg;

  // Default sizes of the slot table and the histogram
  localparam int THREAD_SLOTS_DEF = 1024;
  localparam int HIST_BINS_DEF    = 32;

  // Fixed field widths
  localparam int ACTION_W   = 2;
  localparam int SLOT_IN_W  = 10;
  localparam int GROUP_W    = 23;
  localparam int TIME_W     = 64;
  localparam int BIN_IN_W   = 5;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 64;
  localparam int UNIT_W     = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_GROUP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_UNIT    = 2'd1;

  // Time units and their divisors
  localparam logic [UNIT_W-1:0] UNIT_US = 2'd1;
  localparam logic [UNIT_W-1:0] UNIT_MS = 2'd2;
  localparam int DIV_US = 1000;
  localparam int DIV_MS = 1000000;

  // Threshold width: divisor (below 2^20) shifted by up to 63 bins
  localparam int THR_W = 84;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ENTRY = 2'd0,
    ACT_EXIT  = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_STORED   = 3'd0,
    STAT_FILTERED = 3'd1,
    STAT_RECORDED = 3'd2,
    STAT_NOSTART  = 3'd3,
    STAT_READ     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_REDUCE,
    S_LOOKUP,
    S_SEARCH,
    S_BREAD,
    S_BUPD,
    S_EMIT
  } fsm_e;

  // Divisor of the configured unit; unknown codes count in nanoseconds
  function automatic logic [THR_W-1:0] unit_divisor(input logic [UNIT_W-1:0] unit);
    logic [THR_W-1:0] div;
    case (unit)
      UNIT_US: div = THR_W'(DIV_US);
      UNIT_MS: div = THR_W'(DIV_MS);
      default: div = THR_W'(1);
    endcase
    return div;
  endfunction

endpackage

// ----- rtl/latency_log2_histogram_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latency_log2_histogram_top
// Log2 latency histogram engine with a direct-mapped start time table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one event item: entry,
//   exit or bin read. Every item yields exactly one result item on the
//   output channel (out_valid_o / out_ready_i), in order.
//   Configuration writes (cfg_valid_i / cfg_ready_o) are always taken;
//   index 0 sets the target group, index 1 the time unit.
//   One item is processed at a time. An entry folds its slot into range and
//   stores or filters its start time. An exit folds its slot, looks up and
//   releases the start, runs the bin search, one bit of the bin per cycle
//   against a shifted divisor threshold, and does the read-modify-write of
//   the bin count memory; with no start it ends after the lookup. A read
//   fetches the count of its bin, saturated to the last bin. Folding
//   subtracts THREAD_SLOTS from a slot number at or above it until it is in
//   range (no step when THREAD_SLOTS >= 1024). The next item is taken in
//   the cycle after a result is loaded. After reset a clearing pass wipes
//   the slot table; no item is accepted until it ends. Histogram bins read
//   as zero until first written. A stalled receiver holds the result
//   register; the engine then waits with the next result until the register
//   frees.
// ----------------------------------------------------------------------------
module latency_log2_histogram_top
  import llh_pkg::*;
#(
  parameter int THREAD_SLOTS = THREAD_SLOTS_DEF,
  parameter int HIST_BINS    = HIST_BINS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // event input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ACTION_W-1:0]   action_i,
  input  logic [SLOT_IN_W-1:0]  thread_slot_i,
  input  logic [GROUP_W-1:0]    process_group_i,
  input  logic [TIME_W-1:0]     timestamp_ns_i,
  input  logic [BIN_IN_W-1:0]   bin_index_i,
  // result output channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [BIN_IN_W-1:0]   bin_used_o,
  output logic [COUNT_W-1:0]    bin_count_o
);

  localparam int SLOT_W = $clog2(THREAD_SLOTS);
  localparam int BIN_W  = (HIST_BINS > 2) ? $clog2(HIST_BINS) : 1;
  localparam int ENT_W  = TIME_W + 1;
  localparam logic [BIN_W-1:0] MASK_TOP = BIN_W'(1) << (BIN_W - 1);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  fsm_e                  state_q, state_d;
  logic [SLOT_W-1:0]     clr_q, clr_d;
  logic [GROUP_W-1:0]    tgt_q;
  logic [UNIT_W-1:0]     unit_q;
  logic [HIST_BINS-1:0]  bvalid_q, bvalid_d;
  logic                  out_valid_q, out_valid_d;

  logic [ACTION_W-1:0]   act_q, act_d;
  logic [SLOT_IN_W-1:0]  slot_q, slot_d;
  logic [GROUP_W-1:0]    group_q, group_d;
  logic [TIME_W-1:0]     ts_q, ts_d;
  logic [TIME_W-1:0]     delta_q, delta_d;
  logic [BIN_W-1:0]      ans_q, ans_d;
  logic [BIN_W-1:0]      mask_q, mask_d;
  logic                  hit_q, hit_d;
  status_e               res_status_q, res_status_d;
  logic [BIN_W-1:0]      res_bin_q, res_bin_d;
  logic [COUNT_W-1:0]    res_count_q, res_count_d;
  status_e               out_status_q;
  logic [BIN_W-1:0]      out_bin_q;
  logic [COUNT_W-1:0]    out_count_q;

  // Memories
  logic [ENT_W-1:0]      start_mem [THREAD_SLOTS];
  logic [COUNT_W-1:0]    bin_mem [HIST_BINS];
  logic                  sm_we;
  logic [SLOT_W-1:0]     sm_waddr;
  logic [ENT_W-1:0]      sm_wdata;
  logic [SLOT_W-1:0]     sm_raddr;
  logic [ENT_W-1:0]      sm_rdata_q;
  logic                  bm_we;
  logic [BIN_W-1:0]      bm_addr;
  logic [COUNT_W-1:0]    bm_wdata;
  logic [COUNT_W-1:0]    bm_rdata_q;

  // Helpers
  logic                  in_fire;
  logic                  out_load;
  logic                  slot_ok;
  logic [SLOT_W-1:0]     slot_idx;
  logic                  filtered;
  logic [BIN_W-1:0]      cand;
  logic [THR_W-1:0]      thr;
  logic                  take;
  logic [BIN_W-1:0]      rbin_sat;
  logic [COUNT_W-1:0]    cnt_cur;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign slot_ok     = 32'(slot_q) < THREAD_SLOTS;
  assign slot_idx    = SLOT_W'(slot_q);
  assign filtered    = (tgt_q != '0) && (tgt_q != group_q);
  assign cand        = ans_q | mask_q;
  assign thr         = unit_divisor(unit_q) << cand;
  assign take        = (32'(cand) <= HIST_BINS - 1) && (THR_W'(delta_q) >= thr);
  assign rbin_sat    = (32'(bin_index_i) >= HIST_BINS) ? BIN_W'(HIST_BINS - 1)
                                                       : BIN_W'(bin_index_i);
  assign cnt_cur     = hit_q ? bm_rdata_q : '0;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == SLOT_W'(THREAD_SLOTS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          if (action_i == ACT_ENTRY || action_i == ACT_EXIT) state_d = S_REDUCE;
          else                                                state_d = S_BREAD;
        end
      end
      S_REDUCE: begin
        if (slot_ok) state_d = (act_q == ACT_ENTRY) ? S_EMIT : S_LOOKUP;
      end
      S_LOOKUP: begin
        state_d = sm_rdata_q[TIME_W] ? S_SEARCH : S_EMIT;
      end
      S_SEARCH: begin
        if (mask_q[0]) state_d = S_BREAD;
      end
      S_BREAD: state_d = S_BUPD;
      S_BUPD:  state_d = S_EMIT;
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs and datapath
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready_o   = 1'b0;
    out_load     = 1'b0;
    clr_d        = clr_q;
    act_d        = act_q;
    slot_d       = slot_q;
    group_d      = group_q;
    ts_d         = ts_q;
    delta_d      = delta_q;
    ans_d        = ans_q;
    mask_d       = mask_q;
    hit_d        = hit_q;
    res_status_d = res_status_q;
    res_bin_d    = res_bin_q;
    res_count_d  = res_count_q;
    bvalid_d     = bvalid_q;
    sm_we        = 1'b0;
    sm_waddr     = slot_idx;
    sm_wdata     = '0;
    sm_raddr     = slot_idx;
    bm_we        = 1'b0;
    bm_addr      = ans_q;
    bm_wdata     = cnt_cur + COUNT_W'(1);
    unique case (state_q)
      // wipe the slot table, slot by slot, after reset
      S_CLEAR: begin
        sm_we    = 1'b1;
        sm_waddr = clr_q;
        clr_d    = clr_q + SLOT_W'(1);
      end
      // capture the item
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_fire) begin
          act_d   = action_i;
          slot_d  = thread_slot_i;
          group_d = process_group_i;
          ts_d    = timestamp_ns_i;
          ans_d   = rbin_sat;
        end
      end
      // fold the slot into range, then store or filter the start, or issue the lookup
      S_REDUCE: begin
        if (!slot_ok) begin
          slot_d = slot_q - SLOT_IN_W'(THREAD_SLOTS);
        end else if (act_q == ACT_ENTRY) begin
          sm_we        = !filtered;
          sm_wdata     = {1'b1, ts_q};
          res_status_d = filtered ? STAT_FILTERED : STAT_STORED;
          res_bin_d    = '0;
          res_count_d  = '0;
        end
      end
      // take the elapsed time and release the slot, or report a missing start
      S_LOOKUP: begin
        if (sm_rdata_q[TIME_W]) begin
          delta_d = ts_q - sm_rdata_q[TIME_W-1:0];
          sm_we   = 1'b1;
          ans_d   = '0;
          mask_d  = MASK_TOP;
        end else begin
          res_status_d = STAT_NOSTART;
          res_bin_d    = '0;
          res_count_d  = '0;
        end
      end
      // settle one bin bit a cycle, top down
      S_SEARCH: begin
        if (take) ans_d = cand;
        mask_d = mask_q >> 1;
      end
      // issue the bin count read
      S_BREAD: begin
        hit_d = bvalid_q[ans_q];
      end
      // increment on exit, pass through on read
      S_BUPD: begin
        res_bin_d = ans_q;
        if (act_q == ACT_EXIT) begin
          bm_we           = 1'b1;
          bvalid_d[ans_q] = 1'b1;
          res_status_d    = STAT_RECORDED;
          res_count_d     = bm_wdata;
        end else begin
          res_status_d = STAT_READ;
          res_count_d  = cnt_cur;
        end
      end
      // hand the result to the output register
      S_EMIT: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load)         out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      tgt_q       <= '0;
      unit_q      <= '0;
      bvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      bvalid_q    <= bvalid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_TARGET_GROUP: tgt_q  <= GROUP_W'(cfg_data_i);
          CFG_TIME_UNIT:    unit_q <= cfg_data_i[UNIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    slot_q       <= slot_d;
    group_q      <= group_d;
    ts_q         <= ts_d;
    delta_q      <= delta_d;
    ans_q        <= ans_d;
    mask_q       <= mask_d;
    hit_q        <= hit_d;
    res_status_q <= res_status_d;
    res_bin_q    <= res_bin_d;
    res_count_q  <= res_count_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_bin_q    <= res_bin_q;
      out_count_q  <= res_count_q;
    end
  end

  // --------------------------------------------------------------------------
  // Start time table: valid bit over timestamp
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (sm_we) start_mem[sm_waddr] <= sm_wdata;
    sm_rdata_q <= start_mem[sm_raddr];
  end

  // --------------------------------------------------------------------------
  // Bin count memory
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (bm_we) bin_mem[bm_addr] <= bm_wdata;
    bm_rdata_q <= bin_mem[bm_addr];
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign bin_used_o  = BIN_IN_W'(out_bin_q);
  assign bin_count_o = out_count_q;

endmodule

// ----- tb/sv/llh_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llh_checker
// Watches the configuration, event and result channels of the log2 latency
// histogram engine. It keeps its own slot table and bin counts, predicts the
// result of every accepted event item and compares the results in order.
// ----------------------------------------------------------------------------
module llh_checker
  import llh_pkg::*;
#(
  parameter int THREAD_SLOTS = THREAD_SLOTS_DEF,
  parameter int HIST_BINS    = HIST_BINS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [ACTION_W-1:0]   action_i,
  input  logic [SLOT_IN_W-1:0]  thread_slot_i,
  input  logic [GROUP_W-1:0]    process_group_i,
  input  logic [TIME_W-1:0]     timestamp_ns_i,
  input  logic [BIN_IN_W-1:0]   bin_index_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [STATUS_W-1:0]   status_i,
  input  logic [BIN_IN_W-1:0]   bin_used_i,
  input  logic [COUNT_W-1:0]    bin_count_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    status_e               status;
    logic [BIN_IN_W-1:0]   bin;
    logic [COUNT_W-1:0]    count;
  } hist_result_t;

  // Shadow copy of the engine state and its registers
  logic [TIME_W-1:0]  entry_time [THREAD_SLOTS];
  logic               slot_armed [THREAD_SLOTS];
  logic [COUNT_W-1:0] bin_tally  [HIST_BINS];
  logic [GROUP_W-1:0] group_filter;
  logic [UNIT_W-1:0]  unit_sel;

  hist_result_t hist_results_q [$];
  int           mismatch_count;

  // Index of the highest set bit; zero for zero
  function automatic int unsigned msb_index(logic [TIME_W-1:0] v);
    int unsigned idx;
    idx = 0;
    for (int i = 0; i < TIME_W; i++) begin
      if (v[i]) idx = i;
    end
    return idx;
  endfunction

  // Apply one event to the shadow state and return the result it yields
  function automatic hist_result_t predict_event(logic [ACTION_W-1:0] act,
                                                 logic [SLOT_IN_W-1:0] slot_in,
                                                 logic [GROUP_W-1:0] group,
                                                 logic [TIME_W-1:0] stamp,
                                                 logic [BIN_IN_W-1:0] bin_in);
    hist_result_t res;
    int unsigned  slot;
    int unsigned  bin;
    logic [TIME_W-1:0] elapsed;
    res.status = STAT_READ;
    res.bin    = '0;
    res.count  = '0;
    slot = int'(slot_in) % THREAD_SLOTS;
    case (act)
      ACT_ENTRY: begin
        if (group_filter != '0 && group_filter != group) begin
          res.status = STAT_FILTERED;
        end else begin
          entry_time[slot] = stamp;
          slot_armed[slot] = 1'b1;
          res.status = STAT_STORED;
        end
      end
      ACT_EXIT: begin
        if (!slot_armed[slot]) begin
          res.status = STAT_NOSTART;
        end else begin
          elapsed = stamp - entry_time[slot];
          slot_armed[slot] = 1'b0;
          if (unit_sel == UNIT_US) elapsed = elapsed / TIME_W'(DIV_US);
          else if (unit_sel == UNIT_MS) elapsed = elapsed / TIME_W'(DIV_MS);
          bin = msb_index(elapsed);
          if (bin >= HIST_BINS) bin = HIST_BINS - 1;
          bin_tally[bin] = bin_tally[bin] + 1'b1;
          res.status = STAT_RECORDED;
          res.bin    = BIN_IN_W'(bin);
          res.count  = bin_tally[bin];
        end
      end
      // reads, and the spare action code that behaves as a read
      default: begin
        bin = int'(bin_in);
        if (bin >= HIST_BINS) bin = HIST_BINS - 1;
        res.status = STAT_READ;
        res.bin    = BIN_IN_W'(bin);
        res.count  = bin_tally[bin];
      end
    endcase
    return res;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Track registers, predict on accepted events, compare accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    hist_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < THREAD_SLOTS; i++) slot_armed[i] = 1'b0;
      for (int i = 0; i < HIST_BINS; i++) bin_tally[i] = '0;
      group_filter = '0;
      unit_sel     = '0;
      hist_results_q.delete();
      mismatch_count = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_TARGET_GROUP) group_filter = cfg_data_i[GROUP_W-1:0];
        else if (cfg_index_i == CFG_TIME_UNIT) unit_sel = cfg_data_i[UNIT_W-1:0];
      end
      if (out_valid_i && out_ready_i) begin
        if (hist_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d bin %0d count %0d",
                   $time, status_i, bin_used_i, bin_count_i);
          mismatch_count++;
        end else begin
          want = hist_results_q.pop_front();
          check_field("status", 64'(want.status), 64'(status_i));
          check_field("bin_used", 64'(want.bin), 64'(bin_used_i));
          check_field("bin_count", want.count, bin_count_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        hist_results_q.push_back(predict_event(action_i, thread_slot_i, process_group_i,
                                               timestamp_ns_i, bin_index_i));
      end
      fail_count_o <= mismatch_count;
      pending_o    <= hist_results_q.size();
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the log2 latency histogram engine. A directed
// part hits the edge cases of timing, filtering and binning; random phases
// then pair entries and exits on a small slot pool under changing settings,
// with random gaps on the event side and random stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;
  import llh_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASES       = 7;
  localparam int PHASE_ITEMS  = 100;
  localparam int TAIL_CYCLES  = 20;

  // Codes outside the package enums
  localparam logic [ACTION_W-1:0]  ACT_SPARE   = 2'd3;
  localparam logic [UNIT_W-1:0]    UNIT_NS     = 2'd0;
  localparam logic [UNIT_W-1:0]    UNIT_SPARE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [ACTION_W-1:0]   action;
  logic [SLOT_IN_W-1:0]  thread_slot;
  logic [GROUP_W-1:0]    process_group;
  logic [TIME_W-1:0]     timestamp_ns;
  logic [BIN_IN_W-1:0]   bin_index;
  logic                  out_valid;
  logic                  out_ready;
  logic [STATUS_W-1:0]   status;
  logic [BIN_IN_W-1:0]   bin_used;
  logic [COUNT_W-1:0]    bin_count;
  int                    fail_count;
  int                    pending;
  int                    cycle_count;

  // Stimulus shaping state
  bit                    quiet_phase;
  logic [GROUP_W-1:0]    cur_target;
  logic [SLOT_IN_W-1:0]  slot_pool [16];
  logic [GROUP_W-1:0]    group_pool [4];
  logic [TIME_W-1:0]     slot_stamp [1 << SLOT_IN_W];

  latency_log2_histogram_top u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .action_i        (action),
    .thread_slot_i   (thread_slot),
    .process_group_i (process_group),
    .timestamp_ns_i  (timestamp_ns),
    .bin_index_i     (bin_index),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .status_o        (status),
    .bin_used_o      (bin_used),
    .bin_count_o     (bin_count)
  );

  llh_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .action_i        (action),
    .thread_slot_i   (thread_slot),
    .process_group_i (process_group),
    .timestamp_ns_i  (timestamp_ns),
    .bin_index_i     (bin_index),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .status_i        (status),
    .bin_used_i      (bin_used),
    .bin_count_i     (bin_count),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a run that hangs
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Stall the result side for a random number of cycles per item
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    forever begin
      stall = quiet_phase ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Present one event item after a random gap and hold it until accepted
  task automatic send_event(logic [ACTION_W-1:0] act, logic [SLOT_IN_W-1:0] slot,
                            logic [GROUP_W-1:0] group, logic [TIME_W-1:0] stamp,
                            logic [BIN_IN_W-1:0] bin);
    int unsigned gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    thread_slot   <= slot;
    process_group <= group;
    timestamp_ns  <= stamp;
    bin_index     <= bin;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off events until every predicted result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Drain, then set both registers; upper bits of the unit write are noise.
  // The caller drops the write channel once its last write is done.
  task automatic configure(logic [GROUP_W-1:0] target, logic [UNIT_W-1:0] unit);
    logic [CFG_DATA_W-1:0] unit_word;
    wait_for_results();
    unit_word = CFG_DATA_W'($urandom);
    unit_word[UNIT_W-1:0] = unit;
    write_reg(CFG_TARGET_GROUP, target);
    write_reg(CFG_TIME_UNIT, unit_word);
    cur_target = target;
  endtask

  // One random event, mostly entry and exit pairs on the slot pool
  task automatic random_event();
    int unsigned          pick;
    logic [SLOT_IN_W-1:0] slot;
    logic [GROUP_W-1:0]   group;
    logic [TIME_W-1:0]    stamp;
    logic [TIME_W-1:0]    span;
    slot = ($urandom_range(0, 9) < 7) ? slot_pool[$urandom_range(0, 15)]
                                      : SLOT_IN_W'($urandom);
    group = GROUP_W'($urandom);
    if (cur_target != '0 && $urandom_range(0, 3) != 0) group = cur_target;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      stamp = {$urandom, $urandom};
      slot_stamp[slot] = stamp;
      send_event(ACT_ENTRY, slot, group, stamp, BIN_IN_W'($urandom));
    end else if (pick < 80) begin
      span  = {$urandom, $urandom} >> $urandom_range(0, 63);
      stamp = slot_stamp[slot] + span;
      send_event(ACT_EXIT, slot, group, stamp, BIN_IN_W'($urandom));
    end else begin
      send_event((pick < 95) ? ACT_READ : ACT_SPARE, slot, group, {$urandom, $urandom},
                 BIN_IN_W'($urandom));
    end
  endtask

  initial begin
    logic [TIME_W-1:0] all_ones;
    logic [GROUP_W-1:0] group_max;
    all_ones  = '1;
    group_max = '1;
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    action        = '0;
    thread_slot   = '0;
    process_group = '0;
    timestamp_ns  = '0;
    bin_index     = '0;
    quiet_phase   = 1'b0;
    cur_target    = '0;
    for (int i = 0; i < 16; i++) slot_pool[i] = SLOT_IN_W'($urandom);
    for (int i = 0; i < 4; i++) group_pool[i] = GROUP_W'($urandom);
    for (int i = 0; i < (1 << SLOT_IN_W); i++) slot_stamp[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty bins, spare action, exit with no start
    configure('0, UNIT_NS);
    cfg_valid <= 1'b0;
    send_event(ACT_READ, 10'd0, '0, '0, 5'd0);
    send_event(ACT_SPARE, 10'd0, '0, '0, 5'd31);
    send_event(ACT_EXIT, 10'd5, '0, '0, '0);
    // Zero elapsed time, wrapped elapsed time, largest elapsed time
    send_event(ACT_ENTRY, 10'd0, '0, '0, '0);
    send_event(ACT_EXIT, 10'd0, '0, '0, '0);
    send_event(ACT_ENTRY, 10'd1023, group_max, all_ones, 5'd31);
    send_event(ACT_EXIT, 10'd1023, group_max, 64'd5, 5'd31);
    send_event(ACT_ENTRY, 10'd7, '0, '0, '0);
    send_event(ACT_EXIT, 10'd7, '0, all_ones, '0);
    // Overwrite of a pending start, then a second exit finds the slot clear
    send_event(ACT_ENTRY, 10'd9, '0, 64'd100, '0);
    send_event(ACT_ENTRY, 10'd9, '0, 64'd200, '0);
    send_event(ACT_EXIT, 10'd9, '0, 64'd1224, '0);
    send_event(ACT_EXIT, 10'd9, '0, 64'd5000, '0);
    send_event(ACT_READ, 10'd0, '0, '0, 5'd31);
    send_event(ACT_READ, 10'd0, '0, '0, 5'd10);

    // Directed: largest group filter with microseconds
    configure(group_max, UNIT_US);
    cfg_valid <= 1'b0;
    send_event(ACT_ENTRY, 10'd3, group_max, 64'd1000, '0);
    send_event(ACT_ENTRY, 10'd4, '0, 64'd1000, '0);
    send_event(ACT_EXIT, 10'd4, group_max, 64'd5000, '0);
    send_event(ACT_EXIT, 10'd3, '0, 64'd1999, '0);
    send_event(ACT_ENTRY, 10'd3, group_max, 64'd0, '0);
    send_event(ACT_EXIT, 10'd3, '0, 64'd2000, '0);

    // Directed: milliseconds with a small group, then the spare unit code
    configure(23'd1, UNIT_MS);
    cfg_valid <= 1'b0;
    send_event(ACT_ENTRY, 10'd2, 23'd1, 64'd0, '0);
    send_event(ACT_ENTRY, 10'd6, 23'd2, 64'd0, '0);
    send_event(ACT_EXIT, 10'd2, 23'd2, 64'd5000000, '0);
    configure('0, UNIT_SPARE);
    write_reg(CFG_SPARE_A, group_max);
    write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    send_event(ACT_ENTRY, 10'd8, '0, 64'd10, '0);
    send_event(ACT_EXIT, 10'd8, '0, 64'd13, '0);

    // Random phases, each with its own unit, filter and idling style
    for (int phase = 0; phase < PHASES; phase++) begin
      configure((phase % 2 == 1) ? group_pool[$urandom_range(0, 3)] : '0,
                UNIT_W'(phase % 4));
      if (phase == 3) begin
        write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
        write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom));
      end
      cfg_valid <= 1'b0;
      quiet_phase = (phase == 2) || ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_event();
        if ($urandom_range(0, 39) == 0) wait_for_results();
      end
    end

    // Drain and give the engine time to show any stray result
    quiet_phase = 1'b0;
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
